>>> rtl/gbb_pkg.sv
`default_nettype none

package gbb_pkg;

   localparam int CMD_W      = 3;
   localparam int ID_W       = 6;
   localparam int POS_W      = 16;
   localparam int HALF_W     = 15;
   localparam int NBR_W      = 64;
   localparam int LIVE_W     = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam int UNIT_W     = 5;
   // centre +/- half extent plus ceil rounding, signed
   localparam int EXT_W      = 18;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT  = 3'd0,
      CMD_REMOVE  = 3'd1,
      CMD_REPLACE = 3'd2,
      CMD_UPDATE  = 3'd3,
      CMD_QUERY   = 3'd4
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COLUMNS = 2'd0,
      REG_ROWS    = 2'd1
   } csr_reg_type;

endpackage

`default_nettype wire

>>> rtl/gbb_axis.sv
`default_nettype none

module gbb_axis
   import gbb_pkg::*;
#(
   parameter int UNITS     = 16,
   parameter int FRAC_BITS = 8
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [POS_W-1:0] pos,
   input  logic [HALF_W-1:0]       half,
   input  logic [UNIT_W-1:0]       units,
   output logic [UNITS-1:0]        hits,
   output logic                    nonempty
);

   localparam int CELL_W    = EXT_W - FRAC_BITS;
   localparam int LEN_W     = CELL_W + 1;
   localparam int RCP_SHIFT = CELL_W + UNIT_W;
   localparam int RCP_W     = RCP_SHIFT + 1;
   localparam int PROD_W    = CELL_W + RCP_W;
   localparam int QN_W      = CELL_W + UNIT_W;
   localparam int TAB_N     = 2 ** UNIT_W;
   localparam int D_W       = UNIT_W + 2;
   localparam logic signed [EXT_W-1:0] CEIL_ADD = EXT_W'((1 << FRAC_BITS) - 1);

   // reciprocal and bias residue per modulus
   logic [RCP_W-1:0]  rcp_tab  [TAB_N];
   logic [UNIT_W-1:0] bias_tab [TAB_N];

   for (genvar i = 0; i < TAB_N; i++) begin : g_tab
      localparam longint unsigned DIV  = (i == 0) ? 1 : i;
      localparam longint unsigned RCP  = ((64'd1 << RCP_SHIFT) + DIV - 1) / DIV;
      localparam longint unsigned BMOD = (64'd1 << (CELL_W - 1)) % DIV;
      assign rcp_tab[i]  = RCP_W'(RCP);
      assign bias_tab[i] = UNIT_W'(BMOD);
   end

   // stage 1: cell span
   logic signed [EXT_W-1:0]  pos_ext, half_ext, low_sum, high_sum;
   logic signed [CELL_W-1:0] lo_cell, hi_cell;
   logic [LEN_W-1:0]         span;
   logic [CELL_W-1:0]        biased;
   logic [CELL_W-1:0]        biased_s1_ff, biased_s2_ff;
   logic [LEN_W-1:0]         span_s1_ff, span_s2_ff;

   always_comb begin
      pos_ext  = {{(EXT_W-POS_W){pos[POS_W-1]}}, pos};
      half_ext = {{(EXT_W-HALF_W){1'b0}}, half};
      low_sum  = pos_ext - half_ext;
      high_sum = pos_ext + half_ext + CEIL_ADD;
      lo_cell  = low_sum[EXT_W-1:FRAC_BITS];
      hi_cell  = high_sum[EXT_W-1:FRAC_BITS];
      span     = {hi_cell[CELL_W-1], hi_cell} - {lo_cell[CELL_W-1], lo_cell};
      biased   = {~lo_cell[CELL_W-1], lo_cell[CELL_W-2:0]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         biased_s1_ff <= biased;
         span_s1_ff   <= span;
      end
   end

   // stage 2: quotient by reciprocal
   logic [PROD_W-1:0] prod;
   logic [CELL_W-1:0] quot_s2_ff;

   assign prod = PROD_W'(biased_s1_ff) * PROD_W'(rcp_tab[units]);

   always_ff @(posedge clock) begin
      if (en) begin
         quot_s2_ff   <= prod[RCP_SHIFT +: CELL_W];
         biased_s2_ff <= biased_s1_ff;
         span_s2_ff   <= span_s1_ff;
      end
   end

   // stage 3: start index modulo units
   logic [QN_W-1:0]   qn;
   logic [CELL_W-1:0] rem_wide;
   logic [UNIT_W-1:0] rem, bmod;
   logic [UNIT_W:0]   base_wide;
   logic [UNIT_W-1:0] base_s3_ff, short_s3_ff;
   logic              full_s3_ff, nonempty_s3_ff;

   always_comb begin
      qn       = QN_W'(quot_s2_ff) * QN_W'(units);
      rem_wide = biased_s2_ff - qn[CELL_W-1:0];
      rem      = rem_wide[UNIT_W-1:0];
      bmod     = bias_tab[units];
      if (rem >= bmod) begin
         base_wide = {1'b0, rem} - {1'b0, bmod};
      end else begin
         base_wide = {1'b0, rem} + {1'b0, units} - {1'b0, bmod};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         base_s3_ff     <= base_wide[UNIT_W-1:0];
         short_s3_ff    <= span_s2_ff[UNIT_W-1:0];
         full_s3_ff     <= (span_s2_ff >= LEN_W'(units));
         nonempty_s3_ff <= (span_s2_ff != '0);
      end
   end

   // per-unit coverage, wrapping at units
   always_comb begin
      logic [D_W-1:0] idx, offs;
      for (int c = 0; c < UNITS; c++) begin
         idx = D_W'(c);
         if (idx >= D_W'(base_s3_ff)) begin
            offs = idx - D_W'(base_s3_ff);
         end else begin
            offs = idx + D_W'(units) - D_W'(base_s3_ff);
         end
         hits[c] = (idx < D_W'(units)) && (full_s3_ff || (offs < D_W'(short_s3_ff)));
      end
   end

   assign nonempty = nonempty_s3_ff;

endmodule

`default_nettype wire

>>> rtl/grid_bitset_broadphase_table.sv
// Broad-phase grid table: per-column and per-row entity bitmasks.
// Command channel (req_*): insert, remove, replace, update or neighbourhood
// query for one entity; one result item (rsp_*) per command, in order,
// carrying ok, the neighbour mask and the live count after the command.
// Register port (csr_*): columns and rows in use, always ready; write only
// while no command is in flight.
// Throughput: one command per cycle while results are taken. After the
// input register, three stages compute the cell span and its wrapped start
// index (reciprocal multiply, then remainder); a fourth reads and updates
// all masks at once and loads the result register.
// A stalled receiver freezes the whole pipeline: req_ready follows
// !rsp_valid || rsp_ready, so nothing is lost or repeated.
// Reset clears all masks, the presence mask and the count, empties the
// pipeline and sets both grid sizes to 16 (capped at the grid maximum).
`default_nettype none

module grid_bitset_broadphase_table
   import gbb_pkg::*;
#(
   parameter int MAX_ENTITIES = 64,
   parameter int MAX_COLUMNS  = 16,
   parameter int MAX_ROWS     = 16,
   parameter int FRAC_BITS    = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [CMD_W-1:0]        req_cmd,
   input  logic [ID_W-1:0]         req_entity_id,
   input  logic [ID_W-1:0]         req_new_id,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic [HALF_W-1:0]       req_half_width,
   input  logic [HALF_W-1:0]       req_half_height,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_ok,
   output logic [NBR_W-1:0]        rsp_neighbours,
   output logic [LIVE_W-1:0]       rsp_live_count,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int CNT_W = $clog2(MAX_ENTITIES + 1);
   localparam logic [UNIT_W-1:0] COL_RST = UNIT_W'((MAX_COLUMNS < 16) ? MAX_COLUMNS : 16);
   localparam logic [UNIT_W-1:0] ROW_RST = UNIT_W'((MAX_ROWS < 16) ? MAX_ROWS : 16);

   function automatic logic [UNIT_W-1:0] clamp_units(input logic [CSR_DATA_W-1:0] value,
                                                     input int limit);
      logic [UNIT_W-1:0] result;
      if (value == '0) begin
         result = UNIT_W'(1);
      end else if (int'(value) > limit) begin
         result = UNIT_W'(limit);
      end else begin
         result = UNIT_W'(value);
      end
      return result;
   endfunction

   // configuration
   logic [UNIT_W-1:0] col_units_ff, row_units_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_units_ff <= COL_RST;
         row_units_ff <= ROW_RST;
      end else if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            REG_COLUMNS: col_units_ff <= clamp_units(csr_data, MAX_COLUMNS);
            REG_ROWS:    row_units_ff <= clamp_units(csr_data, MAX_ROWS);
            default:     ;
         endcase
      end
   end

   // pipeline control
   logic pipe_en;
   logic v_s0_ff, v_s1_ff, v_s2_ff, v_s3_ff, rsp_valid_ff;

   assign pipe_en   = !rsp_valid_ff || rsp_ready;
   assign req_ready = pipe_en;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_s0_ff      <= 1'b0;
         v_s1_ff      <= 1'b0;
         v_s2_ff      <= 1'b0;
         v_s3_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         v_s0_ff      <= req_valid;
         v_s1_ff      <= v_s0_ff;
         v_s2_ff      <= v_s1_ff;
         v_s3_ff      <= v_s2_ff;
         rsp_valid_ff <= v_s3_ff;
      end
   end

   // command payload through the span stages
   cmd_type                cmd_s0_ff, cmd_s1_ff, cmd_s2_ff, cmd_s3_ff;
   logic [ID_W-1:0]        id_s0_ff, id_s1_ff, id_s2_ff, id_s3_ff;
   logic [ID_W-1:0]        nid_s0_ff, nid_s1_ff, nid_s2_ff, nid_s3_ff;
   logic signed [POS_W-1:0] pos_x_s0_ff, pos_y_s0_ff;
   logic [HALF_W-1:0]      half_w_s0_ff, half_h_s0_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         cmd_s0_ff    <= cmd_type'(req_cmd);
         id_s0_ff     <= req_entity_id;
         nid_s0_ff    <= req_new_id;
         pos_x_s0_ff  <= req_pos_x;
         pos_y_s0_ff  <= req_pos_y;
         half_w_s0_ff <= req_half_width;
         half_h_s0_ff <= req_half_height;
         cmd_s1_ff    <= cmd_s0_ff;
         id_s1_ff     <= id_s0_ff;
         nid_s1_ff    <= nid_s0_ff;
         cmd_s2_ff    <= cmd_s1_ff;
         id_s2_ff     <= id_s1_ff;
         nid_s2_ff    <= nid_s1_ff;
         cmd_s3_ff    <= cmd_s2_ff;
         id_s3_ff     <= id_s2_ff;
         nid_s3_ff    <= nid_s2_ff;
      end
   end

   logic [MAX_COLUMNS-1:0] col_cover;
   logic [MAX_ROWS-1:0]    row_cover;
   logic                   col_nonempty, row_nonempty;

   gbb_axis #(
      .UNITS     (MAX_COLUMNS),
      .FRAC_BITS (FRAC_BITS)
   ) u_axis_x (
      .clock    (clock),
      .en       (pipe_en),
      .pos      (pos_x_s0_ff),
      .half     (half_w_s0_ff),
      .units    (col_units_ff),
      .hits     (col_cover),
      .nonempty (col_nonempty)
   );

   gbb_axis #(
      .UNITS     (MAX_ROWS),
      .FRAC_BITS (FRAC_BITS)
   ) u_axis_y (
      .clock    (clock),
      .en       (pipe_en),
      .pos      (pos_y_s0_ff),
      .half     (half_h_s0_ff),
      .units    (row_units_ff),
      .hits     (row_cover),
      .nonempty (row_nonempty)
   );

   // table state
   logic [MAX_ENTITIES-1:0] col_masks_ff [MAX_COLUMNS];
   logic [MAX_ENTITIES-1:0] col_masks_in [MAX_COLUMNS];
   logic [MAX_ENTITIES-1:0] row_masks_ff [MAX_ROWS];
   logic [MAX_ENTITIES-1:0] row_masks_in [MAX_ROWS];
   logic [MAX_ENTITIES-1:0] present_ff, present_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   logic [MAX_ENTITIES-1:0] ent_oh, new_oh, col_hit, row_hit;
   logic                    id_fits, new_fits, id_here, new_here, mark;
   logic                    ok_in;
   logic [NBR_W-1:0]        nbr_in;

   always_comb begin
      ent_oh   = {{(MAX_ENTITIES-1){1'b0}}, 1'b1} << id_s3_ff;
      new_oh   = {{(MAX_ENTITIES-1){1'b0}}, 1'b1} << nid_s3_ff;
      id_fits  = |ent_oh;
      new_fits = |new_oh;
      id_here  = |(present_ff & ent_oh);
      new_here = |(present_ff & new_oh);
      mark     = col_nonempty && row_nonempty;
      col_hit  = '0;
      row_hit  = '0;
      for (int i = 0; i < MAX_COLUMNS; i++) begin
         if (|(col_masks_ff[i] & ent_oh)) begin
            col_hit = col_hit | col_masks_ff[i];
         end
      end
      for (int i = 0; i < MAX_ROWS; i++) begin
         if (|(row_masks_ff[i] & ent_oh)) begin
            row_hit = row_hit | row_masks_ff[i];
         end
      end
   end

   always_comb begin
      col_masks_in = col_masks_ff;
      row_masks_in = row_masks_ff;
      present_in   = present_ff;
      count_in     = count_ff;
      ok_in        = 1'b0;
      nbr_in       = '0;
      case (cmd_s3_ff)
         CMD_INSERT: begin
            ok_in = id_fits && !id_here;
            if (ok_in) begin
               for (int i = 0; i < MAX_COLUMNS; i++) begin
                  if (mark && col_cover[i]) begin
                     col_masks_in[i] = col_masks_ff[i] | ent_oh;
                  end
               end
               for (int i = 0; i < MAX_ROWS; i++) begin
                  if (mark && row_cover[i]) begin
                     row_masks_in[i] = row_masks_ff[i] | ent_oh;
                  end
               end
               present_in = present_ff | ent_oh;
               count_in   = count_ff + CNT_W'(1);
            end
         end
         CMD_REMOVE: begin
            ok_in = id_here;
            if (ok_in) begin
               for (int i = 0; i < MAX_COLUMNS; i++) begin
                  col_masks_in[i] = col_masks_ff[i] & ~ent_oh;
               end
               for (int i = 0; i < MAX_ROWS; i++) begin
                  row_masks_in[i] = row_masks_ff[i] & ~ent_oh;
               end
               present_in = present_ff & ~ent_oh;
               count_in   = count_ff - CNT_W'(1);
            end
         end
         CMD_REPLACE: begin
            ok_in = id_here && new_fits && !new_here;
            if (ok_in) begin
               for (int i = 0; i < MAX_COLUMNS; i++) begin
                  if (|(col_masks_ff[i] & ent_oh)) begin
                     col_masks_in[i] = (col_masks_ff[i] & ~ent_oh) | new_oh;
                  end
               end
               for (int i = 0; i < MAX_ROWS; i++) begin
                  if (|(row_masks_ff[i] & ent_oh)) begin
                     row_masks_in[i] = (row_masks_ff[i] & ~ent_oh) | new_oh;
                  end
               end
               present_in = (present_ff & ~ent_oh) | new_oh;
            end
         end
         CMD_UPDATE: begin
            ok_in = id_here;
            if (ok_in) begin
               for (int i = 0; i < MAX_COLUMNS; i++) begin
                  col_masks_in[i] = (col_masks_ff[i] & ~ent_oh)
                                  | ((mark && col_cover[i]) ? ent_oh : '0);
               end
               for (int i = 0; i < MAX_ROWS; i++) begin
                  row_masks_in[i] = (row_masks_ff[i] & ~ent_oh)
                                  | ((mark && row_cover[i]) ? ent_oh : '0);
               end
            end
         end
         CMD_QUERY: begin
            ok_in = id_here;
            if (ok_in) begin
               nbr_in = NBR_W'(col_hit & row_hit);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_COLUMNS; i++) begin
            col_masks_ff[i] <= '0;
         end
         for (int i = 0; i < MAX_ROWS; i++) begin
            row_masks_ff[i] <= '0;
         end
         present_ff <= '0;
         count_ff   <= '0;
      end else if (pipe_en && v_s3_ff) begin
         col_masks_ff <= col_masks_in;
         row_masks_ff <= row_masks_in;
         present_ff   <= present_in;
         count_ff     <= count_in;
      end
   end

   // result register
   logic              rsp_ok_ff;
   logic [NBR_W-1:0]  rsp_nbr_ff;
   logic [LIVE_W-1:0] rsp_live_ff;

   always_ff @(posedge clock) begin
      if (pipe_en && v_s3_ff) begin
         rsp_ok_ff   <= ok_in;
         rsp_nbr_ff  <= nbr_in;
         rsp_live_ff <= LIVE_W'(count_in);
      end
   end

   assign rsp_ok         = rsp_ok_ff;
   assign rsp_neighbours = rsp_nbr_ff;
   assign rsp_live_count = rsp_live_ff;

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
   import gbb_pkg::*;

   localparam int GRID_MAX    = 16;
   localparam int FRAC        = 8;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 210;
   localparam int HOLD_CYCLES = 120;
   localparam int DRAIN_CYCLES = 8;
   localparam int IDLE_LIMIT  = 2000;
   localparam logic [CMD_W-1:0] CMD_LAST = '1;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 2'd3;

   typedef struct {
      logic [CMD_W-1:0]        cmd;
      logic [ID_W-1:0]         entity_id;
      logic [ID_W-1:0]         new_id;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [HALF_W-1:0]       half_width;
      logic [HALF_W-1:0]       half_height;
   } grid_cmd_type;

   typedef struct {
      logic              ok;
      logic [NBR_W-1:0]  neighbours;
      logic [LIVE_W-1:0] live_count;
   } grid_rsp_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [CMD_W-1:0]        req_cmd = '0;
   logic [ID_W-1:0]         req_entity_id = '0;
   logic [ID_W-1:0]         req_new_id = '0;
   logic signed [POS_W-1:0] req_pos_x = '0;
   logic signed [POS_W-1:0] req_pos_y = '0;
   logic [HALF_W-1:0]       req_half_width = '0;
   logic [HALF_W-1:0]       req_half_height = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_ok;
   logic [NBR_W-1:0]        rsp_neighbours;
   logic [LIVE_W-1:0]       rsp_live_count;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   grid_bitset_broadphase_table DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_entity_id(req_entity_id),
      .req_new_id(req_new_id),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_half_width(req_half_width),
      .req_half_height(req_half_height),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_ok(rsp_ok),
      .rsp_neighbours(rsp_neighbours),
      .rsp_live_count(rsp_live_count),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // grid table state as the block should hold it
   logic [NBR_W-1:0]      col_mask [GRID_MAX];
   logic [NBR_W-1:0]      row_mask [GRID_MAX];
   logic [NBR_W-1:0]      present_bits = '0;
   int                    live_total = 0;
   logic [CSR_DATA_W-1:0] cols_reg = CSR_DATA_W'(16);
   logic [CSR_DATA_W-1:0] rows_reg = CSR_DATA_W'(16);

   grid_cmd_type queued_cmds [$];
   grid_rsp_type table_replies [$];
   grid_cmd_type req_item;
   bit        req_taken = 1'b0;
   bit        rsp_taken = 1'b0;
   bit        no_gaps = 1'b0;
   bit        hold_request = 1'b0;
   int        send_wait = 0;
   int        rsp_wait = 0;
   int        mismatches = 0;
   int        idle_cycles = 0;

   int phase_cols [PHASES] = '{1, 16, 0, 7, 31, 5, 16, 3, 12};
   int phase_rows [PHASES] = '{1, 16, 31, 3, 0, 12, 1, 16, 9};

   function automatic int units(logic [CSR_DATA_W-1:0] r);
      if (r == 0) return 1;
      return (r > GRID_MAX) ? GRID_MAX : int'(r);
   endfunction

   function automatic logic [GRID_MAX-1:0] span_cells(int start, int len, int n);
      logic [GRID_MAX-1:0] cells;
      int base;
      int cnt;
      cells = '0;
      cnt = (len < n) ? len : n;
      base = start % n;
      if (base < 0) base += n;
      for (int k = 0; k < cnt; k++) cells[(base + k) % n] = 1'b1;
      return cells;
   endfunction

   function automatic bit id_live(logic [ID_W-1:0] id);
      return live_total > 0 && present_bits[id];
   endfunction

   function automatic bit table_insert(grid_cmd_type c);
      int lox, hix, loy, hiy;
      logic [GRID_MAX-1:0] cols, rows;
      if (id_live(c.entity_id)) return 1'b0;
      lox = (int'(c.pos_x) - int'(c.half_width)) >>> FRAC;
      hix = (int'(c.pos_x) + int'(c.half_width) + (1 << FRAC) - 1) >>> FRAC;
      loy = (int'(c.pos_y) - int'(c.half_height)) >>> FRAC;
      hiy = (int'(c.pos_y) + int'(c.half_height) + (1 << FRAC) - 1) >>> FRAC;
      if (hix > lox && hiy > loy) begin
         cols = span_cells(lox, hix - lox, units(cols_reg));
         rows = span_cells(loy, hiy - loy, units(rows_reg));
         for (int i = 0; i < GRID_MAX; i++) begin
            if (cols[i]) col_mask[i][c.entity_id] = 1'b1;
            if (rows[i]) row_mask[i][c.entity_id] = 1'b1;
         end
      end
      present_bits[c.entity_id] = 1'b1;
      live_total++;
      return 1'b1;
   endfunction

   function automatic bit table_remove(logic [ID_W-1:0] id);
      if (!id_live(id)) return 1'b0;
      for (int i = 0; i < GRID_MAX; i++) begin
         col_mask[i][id] = 1'b0;
         row_mask[i][id] = 1'b0;
      end
      present_bits[id] = 1'b0;
      live_total--;
      return 1'b1;
   endfunction

   function automatic bit table_rename(logic [ID_W-1:0] a, logic [ID_W-1:0] b);
      if (!id_live(a) || id_live(b)) return 1'b0;
      for (int i = 0; i < GRID_MAX; i++) begin
         if (col_mask[i][a]) begin
            col_mask[i][a] = 1'b0;
            col_mask[i][b] = 1'b1;
         end
         if (row_mask[i][a]) begin
            row_mask[i][a] = 1'b0;
            row_mask[i][b] = 1'b1;
         end
      end
      present_bits[a] = 1'b0;
      present_bits[b] = 1'b1;
      return 1'b1;
   endfunction

   function automatic logic [NBR_W-1:0] shared_cells(logic [ID_W-1:0] id);
      logic [NBR_W-1:0] c, r;
      c = '0;
      r = '0;
      for (int i = 0; i < GRID_MAX; i++) begin
         if (col_mask[i][id]) c |= col_mask[i];
         if (row_mask[i][id]) r |= row_mask[i];
      end
      return c & r;
   endfunction

   function automatic grid_rsp_type apply_command(grid_cmd_type c);
      grid_rsp_type r;
      r.ok = 1'b0;
      r.neighbours = '0;
      case (c.cmd)
         CMD_INSERT: r.ok = table_insert(c);
         CMD_REMOVE: r.ok = table_remove(c.entity_id);
         CMD_REPLACE: r.ok = table_rename(c.entity_id, c.new_id);
         CMD_UPDATE: begin
            r.ok = table_remove(c.entity_id);
            if (r.ok) r.ok = table_insert(c);
         end
         CMD_QUERY: begin
            r.ok = id_live(c.entity_id);
            if (r.ok) r.neighbours = shared_cells(c.entity_id);
         end
         default: ;
      endcase
      r.live_count = LIVE_W'(live_total);
      return r;
   endfunction

   function automatic grid_cmd_type mk(logic [CMD_W-1:0] cmd, int id, int nid, int px, int py,
                                       int hw, int hh);
      grid_cmd_type c;
      c.cmd = cmd;
      c.entity_id = ID_W'(id);
      c.new_id = ID_W'(nid);
      c.pos_x = POS_W'(px);
      c.pos_y = POS_W'(py);
      c.half_width = HALF_W'(hw);
      c.half_height = HALF_W'(hh);
      return c;
   endfunction

   function automatic grid_cmd_type random_cmd(int id_lo, int id_top);
      grid_cmd_type c;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) c.cmd = CMD_INSERT;
      else if (pick < 50) c.cmd = CMD_REMOVE;
      else if (pick < 60) c.cmd = CMD_REPLACE;
      else if (pick < 75) c.cmd = CMD_UPDATE;
      else if (pick < 97) c.cmd = CMD_QUERY;
      else c.cmd = CMD_W'($urandom_range(CMD_QUERY + 1, CMD_LAST));
      c.entity_id = ID_W'($urandom_range(id_lo, id_top));
      c.new_id = ID_W'($urandom_range(id_lo, id_top));
      if ($urandom_range(0, 9) == 0) begin
         c.pos_x = POS_W'($urandom);
         c.pos_y = POS_W'($urandom);
         c.half_width = HALF_W'($urandom);
         c.half_height = HALF_W'($urandom);
      end else begin
         c.pos_x = POS_W'($urandom_range(0, 12800) - 6400);
         c.pos_y = POS_W'($urandom_range(0, 12800) - 6400);
         c.half_width = HALF_W'($urandom_range(0, 1024));
         c.half_height = HALF_W'($urandom_range(0, 1024));
      end
      // cell-aligned edges now and then
      if ($urandom_range(0, 3) == 0) begin
         c.pos_x[FRAC-1:0] = '0;
         c.pos_y[FRAC-1:0] = '0;
         c.half_width[FRAC-1:0] = '0;
         c.half_height[FRAC-1:0] = '0;
      end
      return c;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == REG_COLUMNS) cols_reg = data;
      else if (idx == REG_ROWS) rows_reg = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (queued_cmds.size() != 0 || req_valid || table_replies.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // sender
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken || !req_valid) begin
            if (req_taken) begin
               req_taken = 1'b0;
               send_wait = no_gaps ? 0 : $urandom_range(0, 16);
            end
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (queued_cmds.size() > 0) begin
               req_item = queued_cmds.pop_front();
               req_valid <= 1'b1;
               req_cmd <= req_item.cmd;
               req_entity_id <= req_item.entity_id;
               req_new_id <= req_item.new_id;
               req_pos_x <= req_item.pos_x;
               req_pos_y <= req_item.pos_y;
               req_half_width <= req_item.half_width;
               req_half_height <= req_item.half_height;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            if (hold_request) begin
               rsp_wait = HOLD_CYCLES;
               hold_request = 1'b0;
            end else begin
               rsp_wait = no_gaps ? 0 : $urandom_range(0, 16);
            end
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // prediction, checking and watchdog
   always @(posedge clock) begin
      grid_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            table_replies.push_back(apply_command(req_item));
            req_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_taken = 1'b1;
            if (table_replies.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected item ok=%0d neighbours=%h live_count=%0d",
                        $time, rsp_ok, rsp_neighbours, rsp_live_count);
            end else begin
               want = table_replies.pop_front();
               if (rsp_ok !== want.ok) begin
                  mismatches++;
                  $display("%0t: ok expected %0d actual %0d", $time, want.ok, rsp_ok);
               end
               if (rsp_neighbours !== want.neighbours) begin
                  mismatches++;
                  $display("%0t: neighbours expected %h actual %h",
                           $time, want.neighbours, rsp_neighbours);
               end
               if (rsp_live_count !== want.live_count) begin
                  mismatches++;
                  $display("%0t: live_count expected %0d actual %0d",
                           $time, want.live_count, rsp_live_count);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      int id_lo;
      int id_top;
      for (int i = 0; i < GRID_MAX; i++) begin
         col_mask[i] = '0;
         row_mask[i] = '0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // failing commands on an empty table
      queued_cmds.push_back(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0));
      queued_cmds.push_back(mk(CMD_REMOVE, 63, 0, 0, 0, 0, 0));
      queued_cmds.push_back(mk(CMD_REPLACE, 0, 1, 0, 0, 0, 0));
      queued_cmds.push_back(mk(CMD_UPDATE, 5, 0, 0, 0, 0, 0));
      for (int k = CMD_QUERY + 1; k <= CMD_LAST; k++)
         queued_cmds.push_back(mk(CMD_W'(k), 7, 8, 100, 100, 100, 100));
      // zero-size entity, then duplicate insert
      queued_cmds.push_back(mk(CMD_INSERT, 0, 0, 0, 0, 0, 0));
      queued_cmds.push_back(mk(CMD_INSERT, 0, 0, 0, 0, 0, 0));
      queued_cmds.push_back(mk(CMD_INSERT, 1, 0, 384, 384, 128, 128));
      // extreme fields: span covers every cell
      queued_cmds.push_back(mk(CMD_INSERT, 63, 0, -32768, 32767, 32767, 32767));
      // negative position wraps
      queued_cmds.push_back(mk(CMD_INSERT, 2, 0, -832, -832, 256, 256));
      // empty row span marks nothing
      queued_cmds.push_back(mk(CMD_INSERT, 4, 0, 256, 256, 128, 0));
      queued_cmds.push_back(mk(CMD_QUERY, 1, 0, 0, 0, 0, 0));
      queued_cmds.push_back(mk(CMD_QUERY, 63, 0, 0, 0, 0, 0));
      queued_cmds.push_back(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0));
      queued_cmds.push_back(mk(CMD_QUERY, 2, 0, 0, 0, 0, 0));
      queued_cmds.push_back(mk(CMD_REPLACE, 1, 3, 0, 0, 0, 0));
      queued_cmds.push_back(mk(CMD_REPLACE, 3, 3, 0, 0, 0, 0));
      queued_cmds.push_back(mk(CMD_REPLACE, 3, 63, 0, 0, 0, 0));
      queued_cmds.push_back(mk(CMD_UPDATE, 2, 0, 4096, 4096, 640, 64));
      queued_cmds.push_back(mk(CMD_REMOVE, 63, 0, 0, 0, 0, 0));
      queued_cmds.push_back(mk(CMD_QUERY, 3, 0, 0, 0, 0, 0));
      queued_cmds.push_back(mk(CMD_UPDATE, 0, 0, 32767, -32768, 32767, 0));
      queued_cmds.push_back(mk(CMD_REMOVE, 4, 0, 0, 0, 0, 0));
      drain();

      for (int p = 0; p < PHASES; p++) begin
         write_reg(REG_COLUMNS, CSR_DATA_W'(phase_cols[p]));
         write_reg(REG_ROWS, CSR_DATA_W'(phase_rows[p]));
         if (p == 2) begin
            write_reg(REG_SPARE_A, CSR_DATA_W'($urandom));
            write_reg(REG_SPARE_B, CSR_DATA_W'($urandom));
         end
         if (p % 3 == 0) begin
            id_lo = 0;
            id_top = (1 << ID_W) - 1;
         end else begin
            id_lo = $urandom_range(0, (1 << ID_W) - 16);
            id_top = id_lo + 15;
         end
         no_gaps = (p == 4 || p == 6);
         // long receiver stall while the sender keeps pushing
         hold_request = (p == 4);
         for (int i = 0; i < PHASE_ITEMS; i++)
            queued_cmds.push_back(random_cmd(id_lo, id_top));
         drain();
      end

      if (mismatches == 0 && table_replies.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/gbb_pkg.sv
rtl/gbb_axis.sv
rtl/grid_bitset_broadphase_table.sv
tb/sv/tb.sv
